// ===== hdl/b64e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CH_PLUS    = 8'h2b; // '+'
  localparam logic [7:0] CH_SLASH   = 8'h2f; // '/'
  localparam logic [7:0] CH_EQUALS  = 8'h3d; // '='
  localparam logic [7:0] CH_PERCENT = 8'h25; // '%'
  localparam logic [7:0] CH_TWO     = 8'h32; // '2'
  localparam logic [7:0] CH_THREE   = 8'h33; // '3'
  localparam logic [7:0] CH_UPPER_B = 8'h42; // 'B'
  localparam logic [7:0] CH_UPPER_D = 8'h44; // 'D'
  localparam logic [7:0] CH_UPPER_F = 8'h46; // 'F'

  // APB register word index
  localparam logic REG_URL_ESCAPE = 1'b0;

  // One group of up to three bytes, already split into sextets.
  typedef struct packed {
    logic [3:0][5:0] idx;   // sextet k in idx[k]
    logic [1:0]      used;  // bytes in the group, 1..3
    logic            fin;   // group closes the stream
  } grp_t;

  // Position inside a three-character percent escape.
  typedef enum logic [1:0] {
    ESC_PCT = 2'd0,
    ESC_HI  = 2'd1,
    ESC_LO  = 2'd2
  } esc_phase_e;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    c = {2'b00, v};
    if (v < 6'd26)      b64_char = 8'h41 + c;          // 'A'..
    else if (v < 6'd52) b64_char = 8'h61 + c - 8'd26;  // 'a'..
    else if (v < 6'd62) b64_char = 8'h30 + c - 8'd52;  // '0'..
    else if (v == 6'd62) b64_char = CH_PLUS;
    else                 b64_char = CH_SLASH;
  endfunction

endpackage

// ===== hdl/b64e_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Gathers input bytes into groups of three and emits one sextet group per
// complete or final-flushed group.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_data_i,
  input  logic          in_last_i,
  input  logic          q_full_i,
  output logic          in_ready_o,
  output logic          push_o,
  output b64e_pkg::grp_t grp_o
);
  import b64e_pkg::*;

  logic [7:0] held0_q, held1_q;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;
  logic [7:0] g0, g1, g2;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Group closes on the third byte or on the final byte.
  assign push_o = accept && (in_last_i || cnt_q >= 2'd2);

  always_comb begin
    g0 = held0_q;
    g1 = held1_q;
    g2 = in_data_i;
    grp_o.used = 2'd3;
    if (cnt_q == 2'd0) begin
      g0 = in_data_i;
      g1 = 8'h00;
      g2 = 8'h00;
      grp_o.used = 2'd1;
    end else if (cnt_q == 2'd1) begin
      g1 = in_data_i;
      g2 = 8'h00;
      grp_o.used = 2'd2;
    end
    grp_o.idx[0] = g0[7:2];
    grp_o.idx[1] = {g0[1:0], g1[7:4]};
    grp_o.idx[2] = {g1[3:0], g2[7:6]};
    grp_o.idx[3] = g2[5:0];
    grp_o.fin    = in_last_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (push_o) cnt_d = 2'd0;
      else        cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !push_o && cnt_q == 2'd0) held0_q <= in_data_i;
    if (accept && !push_o && cnt_q == 2'd1) held1_q <= in_data_i;
  end

endmodule

// ===== hdl/b64e_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_fifo
// Short group queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::grp_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output b64e_pkg::grp_t head_o
);
  import b64e_pkg::*;

  grp_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ===== hdl/b64e_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Walks the queued group one character per cycle while the output is not
// stalled, expands escapes and drives the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           url_escape_i,
  input  logic           grp_valid_i,
  input  b64e_pkg::grp_t grp_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_char_o,
  output logic           out_last_o,
  output logic           out_end_o
);
  import b64e_pkg::*;

  esc_phase_e phase_q, phase_d;
  logic [1:0] slot_q, slot_d;
  logic       vld_q;
  logic [7:0] char_q;
  logic       last_q, end_q;

  logic       load;
  logic [7:0] base_c, emit_c;
  logic       special, slot_done, grp_done;

  assign load = grp_valid_i && (!vld_q || out_ready_i);

  always_comb begin
    base_c    = (slot_q <= grp_i.used) ? b64_char(grp_i.idx[slot_q]) : CH_EQUALS;
    special   = url_escape_i &&
                (base_c == CH_PLUS || base_c == CH_SLASH || base_c == CH_EQUALS);
    emit_c    = base_c;
    slot_done = 1'b1;
    phase_d   = phase_q;
    slot_d    = slot_q;
    if (special) begin
      case (phase_q)
        ESC_PCT: begin
          emit_c    = CH_PERCENT;
          slot_done = 1'b0;
        end
        ESC_HI: begin
          emit_c    = (base_c == CH_EQUALS) ? CH_THREE : CH_TWO;
          slot_done = 1'b0;
        end
        ESC_LO: begin
          emit_c = (base_c == CH_PLUS)  ? CH_UPPER_B :
                   (base_c == CH_SLASH) ? CH_UPPER_F : CH_UPPER_D;
        end
        default: begin
          emit_c = base_c;
        end
      endcase
    end
    grp_done = slot_done && (slot_q == 2'd3);
    if (load) begin
      if (slot_done) begin
        phase_d = ESC_PCT;
        slot_d  = slot_q + 2'd1;
      end else if (phase_q == ESC_PCT) begin
        phase_d = ESC_HI;
      end else begin
        phase_d = ESC_LO;
      end
    end
  end

  assign pop_o = load && grp_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ESC_PCT;
      slot_q  <= 2'd0;
      vld_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      if (load)             vld_q <= 1'b1;
      else if (out_ready_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= emit_c;
      last_q <= grp_done;
      end_q  <= grp_done && grp_i.fin;
    end
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign out_end_o   = end_q;

endmodule

// ===== hdl/base64_encoder_url_escape.sv =====
`timescale 1ns / 1ps
// A byte that closes a group is written into the group queue, then its first
//   character into the output register; the rest follow one per cycle while
//   m_axis_tready is high. Throughput: one byte per cycle while the group queue
//   has room; the output register emits one character per cycle when not stalled,
//   so three bytes give 4 characters plain and up to 12 with all of them escaped.
// Reset: rst_ni asynchronous, active low; clears pending count, queue, output.
// ----------------------------------------------------------------------------
// base64_encoder_url_escape
// Streaming base64 encoder with optional percent escaping of '+', '/', '='.
// ----------------------------------------------------------------------------
module base64_encoder_url_escape (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // final_byte
  // encoded character stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // [0] stream_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b64e_pkg::*;

  logic url_escape_q;
  logic q_full, q_empty, push, pop;
  grp_t grp_in, grp_head;

  // Config register. Word address decoded from paddr[2]; byte lanes ignored.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_escape_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_URL_ESCAPE) begin
      url_escape_q <= pwdata[0];
    end
  end
  assign prdata = (paddr[2] == REG_URL_ESCAPE) ? {31'd0, url_escape_q} : 32'd0;

  // Front: byte gathering into groups of three.
  b64e_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .grp_o      (grp_in)
  );

  // Group queue decouples byte intake from character output.
  b64e_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (grp_in),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (grp_head)
  );

  // Back: one character per beat, escape expansion, output register.
  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .url_escape_i (url_escape_q),
    .grp_valid_i  (!q_empty),
    .grp_i        (grp_head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_end_o    (m_axis_tuser)
  );

endmodule

// ===== hdl/b64e_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks for the base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64e_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);
  import b64e_pkg::*;

  // A stalled beat holds its character.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // End of stream is always the last character of its group.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("stream end without run last");

  // A percent sign opens an escape, so it never closes a run.
  a_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == CH_PERCENT |-> !m_axis_tlast)
    else $error("escape cut short");

  // Reading back the escape register returns what was written.
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == 3'd0 ##1 paddr == 3'd0
    |-> prdata[0] == $past(pwdata[0]))
    else $error("config readback mismatch");

endmodule

bind base64_encoder_url_escape b64e_checker u_b64e_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

// ===== verif/b64e_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_stream_checker
// Watches the byte, character and APB channels of the encoder, predicts
// every encoded character and compares each output beat in order.
// ----------------------------------------------------------------------------
module b64e_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          chars_pending,
  output int          chars_checked
);
  import b64e_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       stream_end;
  } enc_char_t;

  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t   exp_chars[$];
  enc_char_t   burst[12];
  int          burst_n;
  logic        esc_on;
  logic [7:0]  held_b[2];
  logic [1:0]  held_n;
  int          n_fail;
  int          n_checked;

  initial begin
    fail_count    = 0;
    chars_pending = 0;
    chars_checked = 0;
    n_fail        = 0;
    n_checked     = 0;
    esc_on        = 1'b0;
    held_n        = '0;
  end

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    int unsigned pos;
    pos = 511 - 8 * int'(v);
    return ALPHABET[pos -: 8];
  endfunction

  task automatic push_raw(input logic [7:0] c);
    burst[burst_n] = '{ch: c, run_last: 1'b0, stream_end: 1'b0};
    burst_n++;
  endtask

  task automatic push_char(input logic [7:0] c);
    logic [7:0] hi;
    logic [7:0] lo;
    if (esc_on && (c == CH_PLUS || c == CH_SLASH || c == CH_EQUALS)) begin
      hi = (c == CH_EQUALS) ? CH_THREE : CH_TWO;
      lo = (c == CH_PLUS) ? CH_UPPER_B : (c == CH_SLASH) ? CH_UPPER_F : CH_UPPER_D;
      push_raw(CH_PERCENT);
      push_raw(hi);
      push_raw(lo);
    end else begin
      push_raw(c);
    end
  endtask

  // Group bookkeeping: a byte either parks in the holding slots or closes
  // a group, which then turns into 4 sextets, '='-padded on a short flush.
  task automatic predict_byte(input logic [7:0] b, input logic fin);
    logic [7:0] g0;
    logic [7:0] g1;
    logic [7:0] g2;
    logic [5:0] sx[4];
    int         used;
    int         k;
    if (!fin && held_n == 2'd0) begin
      held_b[0] = b;
      held_n    = 2'd1;
    end else if (!fin && held_n == 2'd1) begin
      held_b[1] = b;
      held_n    = 2'd2;
    end else begin
      if (held_n == 2'd0) begin
        g0 = b;         g1 = 8'h00;     g2 = 8'h00; used = 1;
      end else if (held_n == 2'd1) begin
        g0 = held_b[0]; g1 = b;         g2 = 8'h00; used = 2;
      end else begin
        g0 = held_b[0]; g1 = held_b[1]; g2 = b;     used = 3;
      end
      held_n = 2'd0;
      sx[0] = g0[7:2];
      sx[1] = {g0[1:0], g1[7:4]};
      sx[2] = {g1[3:0], g2[7:6]};
      sx[3] = g2[5:0];
      burst_n = 0;
      for (k = 0; k < used + 1; k++) push_char(sextet_char(sx[k]));
      for (; k < 4; k++) push_char(CH_EQUALS);
      burst[burst_n-1].run_last   = 1'b1;
      burst[burst_n-1].stream_end = fin;
      for (k = 0; k < burst_n; k++) exp_chars.insert(exp_chars.size(), burst[k]);
    end
  endtask

  task automatic compare_char(input logic [7:0] ch, input logic rl, input logic se);
    enc_char_t want;
    if (exp_chars.size() == 0) begin
      $display("%0t: unexpected character beat: expected none, actual char=%h last=%b end=%b",
               $time, ch, rl, se);
      n_fail++;
    end else begin
      want = exp_chars.pop_front();
      n_checked++;
      if (ch !== want.ch) begin
        $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, ch);
        n_fail++;
      end
      if (rl !== want.run_last) begin
        $display("%0t: run_last mismatch: expected %b, actual %b",
                 $time, want.run_last, rl);
        n_fail++;
      end
      if (se !== want.stream_end) begin
        $display("%0t: stream_end mismatch: expected %b, actual %b",
                 $time, want.stream_end, se);
        n_fail++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_on = 1'b0;
      held_n = '0;
      exp_chars.delete();
    end else begin
      // register traffic; only word 0 exists, the spare word is ignored
      if (psel && penable && pready && paddr[2] == REG_URL_ESCAPE) begin
        if (pwrite) begin
          esc_on = pwdata[0];
        end else if (prdata !== {31'b0, esc_on}) begin
          $display("%0t: url_escape readback mismatch: expected %h, actual %h",
                   $time, {31'b0, esc_on}, prdata);
          n_fail++;
        end
      end
      // output first: a byte taken at this edge cannot show up at this edge
      if (m_axis_tvalid && m_axis_tready)
        compare_char(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        predict_byte(s_axis_tdata, s_axis_tlast);
    end
    fail_count    <= n_fail;
    chars_pending <= exp_chars.size();
    chars_checked <= n_checked;
  end

endmodule

// ===== verif/tb_base64_encoder_url_escape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_encoder_url_escape
// Drives byte streams and escape settings into the base64 encoder; a checker
// beside the block predicts and compares every encoded character.
// ----------------------------------------------------------------------------
module tb_base64_encoder_url_escape;
  import b64e_pkg::*;

  // APB byte addresses: word 0 is url_escape, word 1 is unmapped
  localparam logic [2:0] URL_ESCAPE_ADDR = {REG_URL_ESCAPE, 2'b00};
  localparam logic [2:0] SPARE_ADDR      = 3'd4;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 16;     // covers the pipe after the last beat
  localparam int STALL_CYCLES  = 300;    // long receiver hold-off
  localparam int RANDOM_BYTES  = 65;     // per idling phase

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
  logic        s_axis_tlast = 1'b0; // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] out_char
  logic        m_axis_tlast;       // run_last
  logic        m_axis_tuser;       // [0] stream_end
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   fail_count;
  int   chars_pending;
  int   chars_checked;
  int   cycle_cnt = 0;
  int   tx_idle_pct = 18;
  int   rx_idle_pct = 64;
  int   bytes_sent = 0;
  int   streams_sent = 0;
  logic stall_req = 1'b0;
  logic stall_done = 1'b0;
  int   stall_cnt = 0;

  base64_encoder_url_escape u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  b64e_stream_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count    (fail_count),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Character sink. Random back-pressure per phase; once stall_req rises it
  // holds tready low for a long stretch so the encoder backs up into its
  // input, then goes back to the phase's normal behavior.
  always @(posedge clk_i) begin
    if (stall_req && !stall_done) begin
      m_axis_tready <= 1'b0;
      stall_cnt     <= stall_cnt + 1;
      if (stall_cnt == STALL_CYCLES - 1) stall_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One APB transfer: setup cycle, then access cycle (pready is tied high).
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write url_escape, junk in the upper bits, and read it back.
  task automatic set_escape(input logic on);
    apb_xfer(1'b1, URL_ESCAPE_ADDR, {31'($urandom_range(32'h7fff_ffff)), on});
    apb_xfer(1'b0, URL_ESCAPE_ADDR, '0);
  endtask

  // Offer one beat; valid stays up into the next call unless that one idles.
  task automatic send_byte(input logic [7:0] data, input logic fin);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (fin) streams_sent++;
  endtask

  // Block is idle once every predicted character is out; a parked byte
  // produces nothing, so give the pipe DRAIN_CYCLES more on top.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly uniform bytes; now and then one that yields '+', '/' or all-zero
  // sextets so escapes and padding show up often.
  function automatic logic [7:0] pick_byte();
    logic [7:0] hot[8];
    hot = '{8'hfb, 8'hef, 8'hbe, 8'hff, 8'hf8, 8'h3e, 8'h3f, 8'h00};
    if ($urandom_range(3) == 0) return hot[3'($urandom_range(7))];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_stream(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  task automatic random_phase(input int n_bytes);
    int target;
    int len;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(24, 10) : $urandom_range(9, 1);
      send_stream(len);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: plain alphabet ----
    set_escape(1'b0);
    apb_xfer(1'b1, SPARE_ADDR, 32'hffff_ffff);  // unmapped word, must not stick
    apb_xfer(1'b0, URL_ESCAPE_ADDR, '0);
    send_byte(8'h00, 1'b1);                     // one-byte flush: two '=' pads
    send_byte(8'hff, 1'b0);                     // two-byte flush: one '=' pad
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);                     // final byte closes a group:
    send_byte(8'hef, 1'b0);                     // "++++", no padding
    send_byte(8'hbe, 1'b1);
    send_byte(8'hff, 1'b0);                     // "////" then "AAAA"
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    // ---- directed: percent escapes ----
    set_escape(1'b1);
    send_byte(8'hf8, 1'b1);                     // '+' and "==" all escaped
    send_byte(8'hfb, 1'b0);                     // 12 chars from each group of three
    send_byte(8'hef, 1'b0);
    send_byte(8'hbe, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    // escape toggled while a stream is open: only later characters change
    send_byte(8'hfb, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbe, 1'b0);
    send_byte(8'hfb, 1'b0);
    wait_drained();
    set_escape(1'b0);
    send_byte(8'hef, 1'b1);
    wait_drained();

    // ---- random: sender lightly idle, receiver heavily ----
    set_escape(1'b1);
    random_phase(RANDOM_BYTES);
    wait_drained();

    // ---- random: roles swapped ----
    tx_idle_pct = 64;
    rx_idle_pct = 18;
    set_escape(1'b0);
    random_phase(RANDOM_BYTES);
    wait_drained();

    // ---- random: full rate, with one long sink stall up front ----
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_escape(1'b1);
    stall_req <= 1'b1;
    random_phase(RANDOM_BYTES);
    wait_drained();

    $display("Encoded %0d bytes in %0d streams; %0d characters checked across",
             bytes_sent, streams_sent, chars_checked);
    $display("both escape settings, three idle mixes and one long output stall.");
    if (fail_count == 0 && chars_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
